>>> design/assert_macros.svh
// Assertion macros for the RTL of the converter; only the top level includes them.
// No dependencies; the bodies are empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_CLK(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
   `ASSERT_CLK(lbl, (ante) |-> (cons), msg)
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_IMPLY(lbl, ante, cons, msg)
`endif

`endif

>>> design/yrc_pkg.sv
// Types, coefficients and the channel clamp for the YUYV converter.
// No dependencies.
package yrc_pkg;

   localparam int ACC_W = 19;

   localparam logic signed [ACC_W-1:0] COEF_RV = 19'sd359;
   localparam logic signed [ACC_W-1:0] COEF_GU = 19'sd88;
   localparam logic signed [ACC_W-1:0] COEF_GV = 19'sd183;
   localparam logic signed [ACC_W-1:0] COEF_BU = 19'sd454;
   localparam logic [8:0]              CHROMA_BIAS = 9'd128;

   localparam logic MODE_GRAY = 1'b0;
   localparam logic MODE_RGB  = 1'b1;

   typedef logic signed [ACC_W-1:0] acc_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rgb_type;

   // floor(acc / 256), then saturate to 0..255
   function automatic logic [7:0] clamp_channel(input acc_type acc);
      logic signed [ACC_W-9:0] q;
      logic [7:0]              res;
      q = (ACC_W-8)'(acc >>> 8);
      if (q < 0) begin
         res = 8'd0;
      end else if (q > 11'sd255) begin
         res = 8'd255;
      end else begin
         res = q[7:0];
      end
      return res;
   endfunction

endpackage

>>> design/yuyv_to_rgb_or_gray_converter_unit.sv
// Top level of the YUYV macropixel to RGB888 / grayscale converter.
// Depends on yrc_pkg, yrc_pixel and assert_macros.svh.

// One macropixel transaction is taken on every clock at which start is high;
// busy is always low, so the block sustains one macropixel per cycle. The
// result is loaded into the input register and then into the result
// register, and is then shown on the rsp_ ports, flagged by rsp_valid. The
// receiver cannot stall: it must take each result in the cycle it is shown.
// csr_output_mode selects gray (0, reset value) or RGB (1) and should only be
// written while no transaction is in flight.
`include "assert_macros.svh"

module yuyv_to_rgb_or_gray_converter_unit
   import yrc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,

   input  logic       start,
   output logic       busy,
   input  logic [7:0] req_luma_first,
   input  logic [7:0] req_chroma_blue,
   input  logic [7:0] req_luma_second,
   input  logic [7:0] req_chroma_red,
   input  logic       req_frame_end_in,

   output logic       rsp_valid,
   output logic [7:0] rsp_first_red,
   output logic [7:0] rsp_first_green,
   output logic [7:0] rsp_first_blue,
   output logic [7:0] rsp_second_red,
   output logic [7:0] rsp_second_green,
   output logic [7:0] rsp_second_blue,
   output logic [7:0] rsp_first_gray,
   output logic [7:0] rsp_second_gray,
   output logic       rsp_frame_end_out,

   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic       csr_output_mode
);

   logic       mode_ff, mode_in;

   logic       in_valid_ff;
   logic [7:0] in_y0_ff, in_u_ff, in_y1_ff, in_v_ff;
   logic       in_fe_ff;
   logic       in_mode_ff;

   rgb_type    pix0, pix1;
   rgb_type    out_pix0_ff, out_pix0_in;
   rgb_type    out_pix1_ff, out_pix1_in;
   logic [7:0] out_gray0_ff, out_gray0_in;
   logic [7:0] out_gray1_ff, out_gray1_in;
   logic       out_fe_ff;
   logic       out_valid_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   assign mode_in = (csr_valid && csr_ready) ? csr_output_mode : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_GRAY;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         in_valid_ff  <= start && !busy;
         out_valid_ff <= in_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (start && !busy) begin
         in_y0_ff   <= req_luma_first;
         in_u_ff    <= req_chroma_blue;
         in_y1_ff   <= req_luma_second;
         in_v_ff    <= req_chroma_red;
         in_fe_ff   <= req_frame_end_in;
         in_mode_ff <= mode_ff;
      end
   end

   yrc_pixel u_pixel_first (
      .luma        (in_y0_ff),
      .chroma_blue (in_u_ff),
      .chroma_red  (in_v_ff),
      .pixel       (pix0)
   );

   yrc_pixel u_pixel_second (
      .luma        (in_y1_ff),
      .chroma_blue (in_u_ff),
      .chroma_red  (in_v_ff),
      .pixel       (pix1)
   );

   always_comb begin
      if (in_mode_ff == MODE_RGB) begin
         out_pix0_in  = pix0;
         out_pix1_in  = pix1;
         out_gray0_in = 8'd0;
         out_gray1_in = 8'd0;
      end else begin
         out_pix0_in  = '0;
         out_pix1_in  = '0;
         out_gray0_in = in_y0_ff;
         out_gray1_in = in_y1_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (in_valid_ff) begin
         out_pix0_ff  <= out_pix0_in;
         out_pix1_ff  <= out_pix1_in;
         out_gray0_ff <= out_gray0_in;
         out_gray1_ff <= out_gray1_in;
         out_fe_ff    <= in_fe_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_first_red     = out_pix0_ff.red;
   assign rsp_first_green   = out_pix0_ff.green;
   assign rsp_first_blue    = out_pix0_ff.blue;
   assign rsp_second_red    = out_pix1_ff.red;
   assign rsp_second_green  = out_pix1_ff.green;
   assign rsp_second_blue   = out_pix1_ff.blue;
   assign rsp_first_gray    = out_gray0_ff;
   assign rsp_second_gray   = out_gray1_ff;
   assign rsp_frame_end_out = out_fe_ff;

   `ASSERT_CLK(a_accept_to_result, (start && !busy) |=> ##1 rsp_valid, "missing result")
   `ASSERT_IMPLY(a_gray_excludes_color, rsp_valid && (rsp_first_gray != 8'd0 || rsp_second_gray != 8'd0), out_pix0_ff == '0 && out_pix1_ff == '0, "gray and color both set")
   `ASSERT_CLK(a_csr_write, (csr_valid && csr_ready) |=> mode_ff == $past(csr_output_mode), "mode write lost")
   `ASSERT_CLK(a_mode_follows_item, in_valid_ff |-> in_mode_ff == $past(mode_ff), "mode not captured")

endmodule

>>> design/yrc_pixel.sv
// Fixed-point YUV to RGB conversion of one pixel, combinational.
// Depends on yrc_pkg.
module yrc_pixel
   import yrc_pkg::*;
(
   input  logic [7:0] luma,
   input  logic [7:0] chroma_blue,
   input  logic [7:0] chroma_red,
   output rgb_type    pixel
);

   logic signed [8:0] u_s;
   logic signed [8:0] v_s;
   acc_type           y8;
   acc_type           u_ext;
   acc_type           v_ext;
   acc_type           acc_r;
   acc_type           acc_g;
   acc_type           acc_b;

   assign u_s   = $signed({1'b0, chroma_blue} - CHROMA_BIAS);
   assign v_s   = $signed({1'b0, chroma_red} - CHROMA_BIAS);
   assign u_ext = ACC_W'(u_s);
   assign v_ext = ACC_W'(v_s);
   assign y8    = $signed({3'b000, luma, 8'h00});

   assign acc_r = y8 + v_ext * COEF_RV;
   assign acc_g = y8 - u_ext * COEF_GU - v_ext * COEF_GV;
   assign acc_b = y8 + u_ext * COEF_BU;

   assign pixel.red   = clamp_channel(acc_r);
   assign pixel.green = clamp_channel(acc_g);
   assign pixel.blue  = clamp_channel(acc_b);

endmodule
